// ----- rtl/spd_pkg.sv -----
package spd_pkg;

    // default frame geometry
    localparam int CADU_LENGTH_DEFAULT    = 1024;
    localparam int PAYLOAD_LENGTH_DEFAULT = 882;

    // frame layout
    localparam int HP_W          = 11;
    localparam int VCID_W        = 6;
    localparam int APID_W        = 11;
    localparam int APID_SEL_W    = 12;
    localparam int LEN_W         = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int VCID_POS      = 5;
    localparam int HP_HIGH_POS   = 12;
    localparam int HP_LOW_POS    = 13;
    localparam int PAYLOAD_START = 14;

    localparam logic [HP_W-1:0]       HP_NONE   = '1;
    localparam logic [APID_SEL_W-1:0] APID_RAW  = '1;
    localparam logic [APID_SEL_W-1:0] APID_ANY  = '0;
    localparam logic [LEN_W-1:0]      LEN_ANY   = '0;
    localparam logic [LEN_W-1:0]      LEN_MAX   = '1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_VCID   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_APID   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } spd_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       keep;
    } spd_beat_t;

    typedef struct packed {
        logic advance;
        logic fire;
    } spd_ctrl_t;

    typedef struct packed {
        logic                   write;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } spd_cfg_t;

endpackage

// ----- rtl/spd_in_stage.sv -----
module spd_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  spd_pkg::spd_item_t in_item,
    input  logic              advance,
    output logic              item_valid,
    output spd_pkg::spd_item_t item
);
    import spd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    spd_item_t item_reg;
    logic      load;

    // the stage takes a beat when empty or when its content moves on
    assign in_stall   = valid_reg && !advance;
    assign load       = !in_stall;
    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/spd_core.sv -----
module spd_core #(
    parameter int CADU_LENGTH    = spd_pkg::CADU_LENGTH_DEFAULT,
    parameter int PAYLOAD_LENGTH = spd_pkg::PAYLOAD_LENGTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  spd_pkg::spd_ctrl_t ctrl,
    input  spd_pkg::spd_item_t item,
    input  spd_pkg::spd_cfg_t  cfg,
    output logic               res_valid,
    output spd_pkg::spd_beat_t res
);
    import spd_pkg::*;

    localparam int POS_W = $clog2(CADU_LENGTH);
    localparam int CW    = (POS_W >= HP_W) ? POS_W + 1 : HP_W + 1;

    localparam logic [CW-1:0] C_VCID_POS = CW'(VCID_POS);
    localparam logic [CW-1:0] C_HP_HIGH  = CW'(HP_HIGH_POS);
    localparam logic [CW-1:0] C_HP_LOW   = CW'(HP_LOW_POS);
    localparam logic [CW-1:0] C_PL_START = CW'(PAYLOAD_START);
    localparam logic [CW-1:0] C_PL_END   = CW'(PAYLOAD_START + PAYLOAD_LENGTH);
    localparam logic [CW-1:0] C_PL_LEN   = CW'(PAYLOAD_LENGTH);
    localparam logic [CW-1:0] C_PL_LAST  = CW'(PAYLOAD_LENGTH - 1);
    localparam logic [CW-1:0] C_CADU_LEN = CW'(CADU_LENGTH);

    logic [VCID_W-1:0]     vcid_sel_reg,   vcid_sel_next;
    logic [APID_SEL_W-1:0] apid_sel_reg,   apid_sel_next;
    logic [LEN_W-1:0]      len_sel_reg,    len_sel_next;
    logic [POS_W-1:0]      position_reg,   position_next;
    logic                  selected_reg,   selected_next;
    logic [HP_W-1:0]       hdr_ptr_reg,    hdr_ptr_next;
    logic                  hdr_seen_reg,   hdr_seen_next;
    logic [LEN_W-1:0]      pkt_len_reg,    pkt_len_next;
    logic [APID_W-1:0]     pkt_apid_reg,   pkt_apid_next;
    logic [7:0]            held_byte_reg,  held_byte_next;
    logic                  held_valid_reg, held_valid_next;
    logic                  held_first_reg, held_first_next;

    logic [CW-1:0] pos_x;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] offset;
    logic [CW-1:0] hp_x;
    logic          in_payload;
    logic          hdr_here;
    logic          raw_mode;
    logic          kept;
    logic [LEN_W-1:0]  len_base;
    logic [APID_W-1:0] apid_base;

    assign pos_x    = item.start ? '0 : CW'(position_reg);
    assign pos_inc  = pos_x + CW'(1);
    assign offset   = pos_x - C_PL_START;
    assign hp_x     = CW'(hdr_ptr_reg);
    assign raw_mode = (apid_sel_reg == APID_RAW);
    assign in_payload = (pos_x >= C_PL_START) && (pos_x < C_PL_END) && selected_reg;
    assign hdr_here   = (hp_x < C_PL_LEN) && (offset == hp_x);

    // filter on the packet that is being closed
    always_comb
    begin
        logic apid_ok;
        logic len_ok;
        apid_ok = !apid_sel_reg[APID_SEL_W-1]
                  && ((apid_sel_reg == APID_ANY)
                      || (apid_sel_reg == {1'b0, pkt_apid_reg}));
        len_ok  = (len_sel_reg == LEN_ANY) || (len_sel_reg == pkt_len_reg);
        kept    = (pkt_len_reg >= LEN_W'(2)) && apid_ok && len_ok;
    end

    always_comb
    begin
        vcid_sel_next   = vcid_sel_reg;
        apid_sel_next   = apid_sel_reg;
        len_sel_next    = len_sel_reg;
        position_next   = position_reg;
        selected_next   = selected_reg;
        hdr_ptr_next    = hdr_ptr_reg;
        hdr_seen_next   = hdr_seen_reg;
        pkt_len_next    = pkt_len_reg;
        pkt_apid_next   = pkt_apid_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_first_next = held_first_reg;
        res_valid       = 1'b0;
        res             = '0;
        len_base        = pkt_len_reg;
        apid_base       = pkt_apid_reg;

        if (ctrl.fire)
        begin
            position_next = (pos_inc >= C_CADU_LEN) ? '0 : pos_inc[POS_W-1:0];

            if (pos_x == C_VCID_POS)
            begin
                selected_next = (item.data[VCID_W-1:0] == vcid_sel_reg);
            end
            else if (pos_x == C_HP_HIGH)
            begin
                hdr_ptr_next = {item.data[2:0], hdr_ptr_reg[7:0]};
            end
            else if (pos_x == C_HP_LOW)
            begin
                hdr_ptr_next = {hdr_ptr_reg[HP_W-1:8], item.data};
            end
            else if (in_payload)
            begin
                if (raw_mode)
                begin
                    res_valid  = 1'b1;
                    res.data   = item.data;
                    res.first  = (offset == '0);
                    res.last   = (offset == C_PL_LAST);
                    res.keep   = (offset == C_PL_LAST);
                end
                else if (hdr_here || hdr_seen_reg)
                begin
                    if (held_valid_reg)
                    begin
                        res_valid = 1'b1;
                        res.data  = held_byte_reg;
                        res.first = held_first_reg;
                        res.last  = hdr_here && hdr_seen_reg;
                        res.keep  = hdr_here && hdr_seen_reg && kept;
                    end
                    if (hdr_here)
                    begin
                        // a new packet starts on this byte
                        len_base        = '0;
                        apid_base       = '0;
                        hdr_seen_next   = 1'b1;
                        held_first_next = 1'b1;
                    end
                    else
                    begin
                        held_first_next = !held_valid_reg;
                    end
                    // append the byte to the open packet
                    if (len_base == '0)
                    begin
                        pkt_apid_next = {item.data[2:0], 8'h00};
                    end
                    else if (len_base == LEN_W'(1))
                    begin
                        pkt_apid_next = apid_base | APID_W'(item.data);
                    end
                    else
                    begin
                        pkt_apid_next = apid_base;
                    end
                    pkt_len_next    = (len_base == LEN_MAX) ? len_base : len_base + LEN_W'(1);
                    held_byte_next  = item.data;
                    held_valid_next = 1'b1;
                end
            end
        end

        if (cfg.write)
        begin
            case (cfg.index)
                CFG_VCID:
                begin
                    vcid_sel_next = cfg.data[VCID_W-1:0];
                end
                CFG_APID:
                begin
                    apid_sel_next   = cfg.data[APID_SEL_W-1:0];
                    hdr_seen_next   = 1'b0;
                    held_valid_next = 1'b0;
                    held_first_next = 1'b0;
                    pkt_len_next    = '0;
                    pkt_apid_next   = '0;
                end
                CFG_LENGTH:
                begin
                    len_sel_next = cfg.data[LEN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcid_sel_reg   <= '0;
            apid_sel_reg   <= '0;
            len_sel_reg    <= '0;
            position_reg   <= '0;
            selected_reg   <= 1'b0;
            hdr_ptr_reg    <= HP_NONE;
            hdr_seen_reg   <= 1'b0;
            pkt_len_reg    <= '0;
            pkt_apid_reg   <= '0;
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b0;
        end
        else
        begin
            vcid_sel_reg   <= vcid_sel_next;
            apid_sel_reg   <= apid_sel_next;
            len_sel_reg    <= len_sel_next;
            position_reg   <= position_next;
            selected_reg   <= selected_next;
            hdr_ptr_reg    <= hdr_ptr_next;
            hdr_seen_reg   <= hdr_seen_next;
            pkt_len_reg    <= pkt_len_next;
            pkt_apid_reg   <= pkt_apid_next;
            held_valid_reg <= held_valid_next;
            held_first_reg <= held_first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
    end

`ifndef SYNTHESIS
    a_held_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> hdr_seen_reg)
        else $error("held byte without a packet header");

    a_first_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        held_first_reg |-> held_valid_reg)
        else $error("first mark on an empty hold register");

    a_len_tracks_held: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg == (pkt_len_reg != '0))
        else $error("packet length and hold register disagree");
`endif

endmodule

// ----- rtl/spd_out_stage.sv -----
module spd_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               load_valid,
    input  spd_pkg::spd_beat_t load_beat,
    output logic               out_valid,
    output spd_pkg::spd_beat_t out_beat
);
    import spd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    spd_beat_t beat_reg;

    assign valid_next = advance ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            beat_reg <= load_beat;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ----- rtl/space_packet_demultiplexer.sv -----
// space packet demultiplexer: takes a cadu byte stream one byte per beat
// (cadu_start on byte 0), keeps frames whose vcid (byte 5) matches
// vcid_select and cuts space packets out of the payload at the first-header
// pointer (bytes 12-13). packet bytes leave one per beat with first and last
// marks; out_keep on the last byte tells whether the packet passes the apid
// and length filters. apid_select of -1 sends each frame payload as one
// packet. rate: one input byte per clock sustained unless out_stall holds a
// result beat; a byte goes through an input register, one pass of compare and
// update logic against the frame counter and packet registers, and a result
// register that drives the output ports. inside a packet the result lags by
// one byte, since each byte waits in the hold register until the next one
// tells whether it was the last. configuration is to be written through
// cfg_write only while the block is idle; the block does not enforce this.
module space_packet_demultiplexer #(
    parameter int CADU_LENGTH    = spd_pkg::CADU_LENGTH_DEFAULT,
    parameter int PAYLOAD_LENGTH = spd_pkg::PAYLOAD_LENGTH_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         cadu_byte,
    input  logic                               cadu_start,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         out_byte,
    output logic                               out_first,
    output logic                               out_last,
    output logic                               out_keep,
    // configuration write port
    input  logic                               cfg_write,
    input  logic [spd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import spd_pkg::*;

    spd_item_t in_item;
    spd_item_t item;
    logic      item_valid;
    spd_ctrl_t ctrl;
    spd_cfg_t  cfg;
    logic      res_valid;
    spd_beat_t res;
    spd_beat_t out_beat;

    assign in_item.data  = cadu_byte;
    assign in_item.start = cadu_start;

    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // the whole path moves on unless a result beat is held up downstream
    assign ctrl.advance = !out_valid || !out_stall;
    assign ctrl.fire    = item_valid && ctrl.advance;

    spd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (ctrl.advance),
        .item_valid (item_valid),
        .item       (item)
    );

    spd_core #(
        .CADU_LENGTH    (CADU_LENGTH),
        .PAYLOAD_LENGTH (PAYLOAD_LENGTH)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .item      (item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register holds the beat while the downstream stall lasts
    spd_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (ctrl.advance),
        .load_valid (ctrl.fire && res_valid),
        .load_beat  (res),
        .out_valid  (out_valid),
        .out_beat   (out_beat)
    );

    assign out_byte  = out_beat.data;
    assign out_first = out_beat.first;
    assign out_last  = out_beat.last;
    assign out_keep  = out_beat.keep;

`ifndef SYNTHESIS
    a_keep_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_keep || out_last))
        else $error("keep mark on a beat that does not close a packet");

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result side is free");
`endif

endmodule

// ----- tb/spd_check_pkg.sv -----
package spd_check_pkg;

    import spd_pkg::*;

    localparam int CADU_LEN    = CADU_LENGTH_DEFAULT;
    localparam int PAYLOAD_LEN = PAYLOAD_LENGTH_DEFAULT;

    // predicts the packet beats cut out of the cadu stream and checks them in order
    class packet_scoreboard;

        // register copies
        logic [VCID_W-1:0]     vcid_sel;
        logic [APID_SEL_W-1:0] apid_sel;
        logic [LEN_W-1:0]      len_sel;

        // frame and packet state
        int unsigned           frame_pos;
        bit                    frame_taken;
        logic [HP_W-1:0]       header_ptr;
        bit                    in_packet;
        logic [LEN_W-1:0]      pkt_len;
        logic [APID_W-1:0]     pkt_apid;
        logic [7:0]            held_data;
        bit                    held_full;
        bit                    held_head;

        spd_beat_t             pending_beats [$];
        int                    mismatches;
        int                    beats_seen;
        int                    packets_ended;
        int                    packets_kept;

        function new();
            vcid_sel      = '0;
            apid_sel      = APID_ANY;
            len_sel       = LEN_ANY;
            frame_pos     = 0;
            frame_taken   = 1'b0;
            header_ptr    = HP_NONE;
            held_data     = '0;
            mismatches    = 0;
            beats_seen    = 0;
            packets_ended = 0;
            packets_kept  = 0;
            drop_packet();
        endfunction

        function void drop_packet();
            in_packet = 1'b0;
            held_full = 1'b0;
            held_head = 1'b0;
            pkt_len   = '0;
            pkt_apid  = '0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_VCID:   vcid_sel = value[VCID_W-1:0];
                CFG_APID:
                begin
                    apid_sel = value[APID_SEL_W-1:0];
                    drop_packet();
                end
                CFG_LENGTH: len_sel = value[LEN_W-1:0];
                default:    ;
            endcase
        endfunction

        function void queue_beat(logic [7:0] data, bit first, bit last, bit keep);
            spd_beat_t beat;
            beat.data  = data;
            beat.first = first;
            beat.last  = last;
            beat.keep  = last && keep;
            pending_beats = {pending_beats, beat};
            if (last)
            begin
                packets_ended++;
                if (keep)
                    packets_kept++;
            end
        endfunction

        // first two packet bytes carry the apid, length saturates
        function void take_byte(logic [7:0] b);
            if (pkt_len == 0)
                pkt_apid = {b[2:0], 8'h00};
            else if (pkt_len == 1)
                pkt_apid = {pkt_apid[APID_W-1:8], b};
            if (pkt_len != LEN_MAX)
                pkt_len++;
            held_data = b;
            held_full = 1'b1;
        endfunction

        function void take_cadu_byte(logic [7:0] b, logic start);
            int unsigned pos;
            int unsigned p;
            bit          keep;
            pos       = start ? 0 : frame_pos;
            frame_pos = (pos + 1 >= CADU_LEN) ? 0 : pos + 1;
            if (pos == VCID_POS)
            begin
                frame_taken = (b[VCID_W-1:0] == vcid_sel);
                return;
            end
            if (pos == HP_HIGH_POS)
            begin
                header_ptr[HP_W-1:8] = b[2:0];
                return;
            end
            if (pos == HP_LOW_POS)
            begin
                header_ptr[7:0] = b;
                return;
            end
            if (pos < PAYLOAD_START || pos >= PAYLOAD_START + PAYLOAD_LEN || !frame_taken)
                return;
            p = pos - PAYLOAD_START;
            if (apid_sel == APID_RAW)
            begin
                queue_beat(b, p == 0, p == PAYLOAD_LEN - 1, 1'b1);
                return;
            end
            if (header_ptr < PAYLOAD_LEN && p == header_ptr)
            begin
                if (in_packet && held_full)
                begin
                    keep = pkt_len >= 2 && !apid_sel[APID_SEL_W-1]
                           && (apid_sel == APID_ANY || apid_sel == {1'b0, pkt_apid})
                           && (len_sel == LEN_ANY || len_sel == pkt_len);
                    queue_beat(held_data, held_head, 1'b1, keep);
                end
                in_packet = 1'b1;
                pkt_len   = '0;
                pkt_apid  = '0;
                take_byte(b);
                held_head = 1'b1;
                return;
            end
            if (in_packet)
            begin
                if (held_full)
                    queue_beat(held_data, held_head, 1'b0, 1'b0);
                held_head = !held_full;
                take_byte(b);
            end
        endfunction

        function void check_beat(spd_beat_t seen);
            spd_beat_t want;
            beats_seen++;
            if (pending_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: byte %h first %b last %b keep %b",
                             seen.data, seen.first, seen.last, seen.keep);
                return;
            end
            want = pending_beats.pop_front();
            if (seen !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: expected byte %h first %b last %b keep %b, got %h %b %b %b",
                             beats_seen, want.data, want.first, want.last, want.keep,
                             seen.data, seen.first, seen.last, seen.keep);
            end
        endfunction

    endclass

endpackage

// ----- tb/tb_space_packet_demultiplexer.sv -----
module tb_space_packet_demultiplexer;

    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;
    import spd_check_pkg::*;

    // the one register index the block does not decode
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    localparam int IDLE_PCT       = 32;
    localparam int HOLDOFF_CYCLES = 240;
    localparam int PHASE_BYTES    = 120;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    logic [7:0]             cadu_byte  = '0;
    logic                   cadu_start = 1'b0;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    logic [7:0]             out_byte;
    logic                   out_first;
    logic                   out_last;
    logic                   out_keep;
    logic                   cfg_write  = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;

    packet_scoreboard sb;

    // no random idling on either side while set
    bit calm            = 1'b0;
    // asks the receiver for one long hold-off
    bit holdoff_request = 1'b0;
    int holdoff_left    = 0;
    int bytes_sent      = 0;
    int settings_used   = 0;

    space_packet_demultiplexer #(
        .CADU_LENGTH    (CADU_LEN),
        .PAYLOAD_LENGTH (PAYLOAD_LEN)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cadu_byte  (cadu_byte),
        .cadu_start (cadu_start),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_first  (out_first),
        .out_last   (out_last),
        .out_keep   (out_keep),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side: check every beat taken, then pick the stall for the next edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(spd_beat_t'({out_byte, out_first, out_last, out_keep}));
        if (holdoff_request)
        begin
            holdoff_request = 1'b0;
            holdoff_left    = HOLDOFF_CYCLES;
        end
        // long hold-off lets the block fill up and push back on the sender
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // offer one cadu byte, with random idle cycles ahead of it, and wait for the beat
    task automatic send_byte(input logic [7:0] b, input logic s);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cadu_byte  <= b;
        cadu_start <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_cadu_byte(b, s);
        bytes_sent++;
    endtask

    // one frame of n_bytes: vcid at byte 5, header pointer at bytes 12-13 and
    // the apid of the packet starting at the pointer; everything else random
    task automatic send_frame(input logic [VCID_W-1:0] vc, input logic [HP_W-1:0] ptr,
                              input logic [APID_W-1:0] apid, input int n_bytes,
                              input bit with_start);
        logic [7:0] b;
        int         pos;
        int         p;
        for (pos = 0; pos < n_bytes; pos++)
        begin
            b = 8'($urandom);
            p = pos - PAYLOAD_START;
            if (pos == VCID_POS)
                b[VCID_W-1:0] = vc;
            else if (pos == HP_HIGH_POS)
                b[2:0] = ptr[HP_W-1:8];
            else if (pos == HP_LOW_POS)
                b = ptr[7:0];
            else if (p == int'(ptr))
                b[2:0] = apid[APID_W-1:8];
            else if (p == int'(ptr) + 1)
                b = apid[7:0];
            send_byte(b, with_start && pos == 0);
        end
    endtask

    // sender pauses until every predicted beat is out, then lets the pipe empty
    task automatic drain_results();
        int waited;
        waited   = 0;
        in_valid <= 1'b0;
        while (sb.pending_beats.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    // back-to-back register writes, only while the block is idle
    task automatic configure(input logic [VCID_W-1:0] vc, input logic [APID_SEL_W-1:0] apid,
                             input logic [LEN_W-1:0] len, input bit poke_spare);
        logic [CFG_INDEX_W-1:0] reg_index [4];
        logic [CFG_DATA_W-1:0]  reg_value [4];
        reg_index = '{CFG_VCID, CFG_APID, CFG_LENGTH, CFG_SPARE};
        reg_value = '{CFG_DATA_W'(vc), CFG_DATA_W'(apid), len, CFG_DATA_W'($urandom)};
        for (int i = 0; i < (poke_spare ? 4 : 3); i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= reg_index[i];
            cfg_data  <= reg_value[i];
            @(posedge clk);
            sb.write_register(reg_index[i], reg_value[i]);
        end
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // random frames under one register setting; most are well-formed frames with
    // the header at payload byte 0 so packets match the length filter, the rest
    // random pointers, continuations, foreign channels and cut-short frames
    task automatic run_phase(input logic [VCID_W-1:0] vc, input logic [APID_SEL_W-1:0] apid,
                             input logic [LEN_W-1:0] len, input int pkt_bytes,
                             input bit no_idle, input bit hold_off);
        int                  done;
        int                  nb;
        int                  r;
        logic [VCID_W-1:0]   fvc;
        logic [HP_W-1:0]     ptr;
        logic [APID_W-1:0]   fapid;
        bit                  with_start;
        drain_results();
        configure(vc, apid, len, 1'b0);
        calm = no_idle;
        if (hold_off)
            holdoff_request = 1'b1;
        done = 0;
        while (done < PHASE_BYTES)
        begin
            r          = $urandom_range(0, 99);
            fvc        = ($urandom_range(0, 9) == 0) ? VCID_W'($urandom) : vc;
            fapid      = ($urandom_range(0, 3) == 0) ? APID_W'($urandom) : apid[APID_W-1:0];
            with_start = 1'b1;
            if (r < 55)
            begin
                ptr = '0;
                nb  = PAYLOAD_START + ((pkt_bytes > 0) ? pkt_bytes : $urandom_range(1, 30));
            end
            else if (r < 75)
            begin
                ptr = HP_W'($urandom_range(0, 45));
                nb  = PAYLOAD_START + $urandom_range(1, 40);
            end
            else if (r < 90)
            begin
                // continuation: no header, or a pointer past the payload
                ptr = $urandom_range(0, 1) ? HP_NONE : HP_W'($urandom_range(PAYLOAD_LEN, 2046));
                nb  = PAYLOAD_START + $urandom_range(1, 40);
            end
            else
            begin
                // broken: cut short, sometimes without a start mark
                ptr        = HP_W'($urandom);
                nb         = $urandom_range(1, 16);
                with_start = ($urandom_range(0, 3) != 0);
            end
            send_frame(fvc, ptr, fapid, nb, with_start);
            if (fvc == vc)
                done += nb;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        logic [VCID_W-1:0] vc;
        logic [APID_W-1:0] apid;
        int                plen;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames under the reset settings
        send_frame(6'd0, HP_NONE, 11'd0, PAYLOAD_START + 2, 1'b1);   // no packet open: dropped
        send_frame(6'd0, 11'd1, 11'h7FF, PAYLOAD_START + 4, 1'b1);   // packet opens at byte 1
        send_frame(6'd0, 11'd0, 11'd0, PAYLOAD_START + 1, 1'b1);     // closes it, one-byte packet
        send_frame(6'd0, 11'd0, 11'd5, PAYLOAD_START + 3, 1'b1);     // one-byte packet not kept
        send_frame(6'd7, 11'd0, 11'd0, PAYLOAD_START + 2, 1'b1);     // foreign channel ignored
        send_frame(6'd0, 11'd900, 11'd0, PAYLOAD_START + 2, 1'b1);   // pointer past payload
        send_frame(6'd0, 11'd0, 11'd0, 9, 1'b1);                     // cut short in the header
        drain_results();
        // unused register index must be ignored
        configure(6'd0, APID_ANY, LEN_ANY, 1'b1);
        send_frame(6'd0, 11'd2, 11'd3, PAYLOAD_START + 6, 1'b1);
        send_frame(6'd0, 11'd0, 11'd0, PAYLOAD_START + 2, 1'b1);

        // any apid, any length, random sizes
        run_phase(VCID_W'($urandom), APID_ANY, LEN_ANY, 0, 1'b0, 1'b0);

        // exact apid and length on vcid 63, no idling and one long receiver hold-off
        apid = APID_W'($urandom_range(1, 2047));
        plen = $urandom_range(2, 30);
        run_phase(6'd63, {1'b0, apid}, LEN_W'(plen), plen, 1'b1, 1'b1);

        // largest apid, shortest keepable length
        run_phase(6'd0, 12'h7FF, 16'd2, 2, 1'b0, 1'b0);

        // raw payload per frame
        vc = VCID_W'($urandom);
        run_phase(vc, APID_RAW, LEN_W'($urandom), 0, 1'b0, 1'b0);

        // negative apid other than raw: nothing kept
        plen = $urandom_range(2, 30);
        run_phase(VCID_W'($urandom), {2'b10, 10'($urandom)}, LEN_W'(plen), plen, 1'b0, 1'b0);

        // length 1: every one-byte packet falls below the minimum
        run_phase(VCID_W'($urandom), {1'b0, APID_W'($urandom)}, 16'd1, 1, 1'b0, 1'b0);

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.pending_beats.size() != 0)
        begin
            $display("%0d predicted beats never came out", sb.pending_beats.size());
            sb.mismatches += sb.pending_beats.size();
        end
        $display("run covered %0d cadu bytes under %0d register settings",
                 bytes_sent, settings_used);
        $display("%0d packet beats checked, %0d packets closed, %0d kept, %0d mismatches",
                 sb.beats_seen, sb.packets_ended, sb.packets_kept, sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #15_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
